FILE: design/lbs_pkg.sv
`timescale 1ns / 1ps

package lbs_pkg;

  // Field widths
  localparam int CMD_W    = 1;
  localparam int ID_W     = 16;
  localparam int SIZE_W   = 16;
  localparam int CAP_W    = 20;
  localparam int RATE_W   = 16;
  localparam int STATUS_W = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  // Queue and result limits
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int RES_CNT_W       = $clog2(MAX_RESULTS);

  // Register reset values
  localparam logic [CAP_W-1:0]  CAPACITY_RST  = CAP_W'(1024);
  localparam logic [RATE_W-1:0] LEAK_RATE_RST = RATE_W'(64);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEAK_RATE = 1'b1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED = 3'd0,
    ST_OVER_CAP = 3'd1,
    ST_FULL     = 3'd2,
    ST_SENT     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   packet_id;
    logic [SIZE_W-1:0] packet_size;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   out_packet_id;
    logic [SIZE_W-1:0] units_sent;
    logic              packet_done;
    logic [RATE_W-1:0] tick_total;
    logic              last;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic item_load;
    logic add_commit;
    logic empty_emit;
    logic send_step;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_is_tick;
    logic queue_empty;
    logic rate_zero;
    logic out_free;
    logic send_last;
  } dp_stat_t;

endpackage

FILE: design/lbs_ram.sv
`timescale 1ns / 1ps

module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/lbs_ctrl.sv
`timescale 1ns / 1ps

module lbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lbs_pkg::dp_stat_t stat,
  output lbs_pkg::ctrl_cmd_t cmd
);
  import lbs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_EMPTY,
    S_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;
  logic   accept;

  assign accept   = in_valid && !in_stall_r;
  assign in_stall = in_stall_r;

  // Decode commands and next state
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.item_load = 1'b1;
          priority if (!stat.in_is_tick) begin
            state_nxt = S_ADD;
          end else if (stat.queue_empty) begin
            state_nxt = S_EMPTY;
          end else if (stat.rate_zero) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SEND;
          end
        end
      end
      S_ADD: begin
        if (stat.out_free) begin
          cmd.add_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (stat.out_free) begin
          cmd.empty_emit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_SEND: begin
        if (stat.out_free) begin
          cmd.send_step = 1'b1;
          if (stat.send_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and the registered stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

endmodule

FILE: design/lbs_dp.sv
`timescale 1ns / 1ps

module lbs_dp #(
  parameter int QUEUE_DEPTH = lbs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lbs_pkg::in_item_t             in_data,
  output logic                          out_valid,
  output lbs_pkg::out_item_t            out_data,
  input  logic                          out_stall,
  input  logic                          cfg_we,
  input  logic [lbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  lbs_pkg::ctrl_cmd_t            cmd,
  output lbs_pkg::dp_stat_t             stat
);
  import lbs_pkg::*;

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = ID_W + SIZE_W;

  // Configuration registers
  logic [CAP_W-1:0]  capacity_r;
  logic [RATE_W-1:0] leak_rate_r;

  // Queue control
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CAP_W-1:0] occ_r, occ_nxt;

  // Current request and tick progress
  in_item_t             item_r;
  logic [RATE_W-1:0]    budget_r, budget_nxt;
  logic [RATE_W-1:0]    total_r, total_nxt;
  logic [RES_CNT_W-1:0] k_r, k_nxt;

  // Output register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Queue memory
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [ID_W-1:0]    head_id;
  logic [SIZE_W-1:0]  head_size;

  // Add evaluation
  logic [CAP_W:0] occ_sum;
  logic           over_cap;
  logic           queue_full;
  logic           add_ok;

  // Send evaluation
  logic              split;
  logic [SIZE_W-1:0] sent;
  logic [RATE_W-1:0] budget_after;
  logic [RATE_W-1:0] total_after;
  logic [CNT_W-1:0]  count_after;
  logic              send_last;

  lbs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  assign head_id   = ram_rdata[ENTRY_W-1:SIZE_W];
  assign head_size = ram_rdata[SIZE_W-1:0];

  // Check an add against capacity and free slots
  assign occ_sum    = {1'b0, occ_r} + (CAP_W + 1)'(item_r.packet_size);
  assign over_cap   = occ_sum > {1'b0, capacity_r};
  assign queue_full = (count_r == CNT_W'(QUEUE_DEPTH));
  assign add_ok     = !over_cap && !queue_full;

  // Drain the head entry against the remaining budget
  assign split        = head_size > budget_r;
  assign sent         = split ? budget_r : head_size;
  assign budget_after = budget_r - sent;
  assign total_after  = total_r + sent;
  assign count_after  = split ? count_r : count_r - 1'b1;
  assign send_last    = split || (count_after == '0) || (budget_after == '0) ||
                        (k_r == RES_CNT_W'(MAX_RESULTS - 1));

  // Status to the controller
  assign stat.in_is_tick  = (in_data.command == CMD_TICK);
  assign stat.queue_empty = (count_r == '0);
  assign stat.rate_zero   = (leak_rate_r == '0);
  assign stat.out_free    = !out_valid_r || !out_stall;
  assign stat.send_last   = send_last;

  // Write the tail on add, the shrunk head on a split
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail_r;
    ram_wdata = {item_r.packet_id, item_r.packet_size};
    if (cmd.add_commit && add_ok) begin
      ram_we = 1'b1;
    end else if (cmd.send_step && split) begin
      ram_we    = 1'b1;
      ram_waddr = head_r;
      ram_wdata = {head_id, head_size - budget_r};
    end
  end

  // Advance queue state and tick progress
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    occ_nxt    = occ_r;
    budget_nxt = budget_r;
    total_nxt  = total_r;
    k_nxt      = k_r;
    if (cmd.item_load) begin
      budget_nxt = leak_rate_r;
      total_nxt  = '0;
      k_nxt      = '0;
    end
    if (cmd.add_commit && add_ok) begin
      tail_nxt  = (tail_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
      occ_nxt   = occ_sum[CAP_W-1:0];
    end
    if (cmd.send_step) begin
      if (!split) begin
        head_nxt = (head_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      end
      count_nxt  = count_after;
      occ_nxt    = (occ_r >= CAP_W'(sent)) ? occ_r - CAP_W'(sent) : '0;
      budget_nxt = budget_after;
      total_nxt  = total_after;
      k_nxt      = k_r + 1'b1;
    end
  end

  // Load the output register, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.add_commit) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt               = '0;
      out_data_nxt.out_packet_id = item_r.packet_id;
      out_data_nxt.last          = 1'b1;
      priority if (over_cap) begin
        out_data_nxt.status = ST_OVER_CAP;
      end else if (queue_full) begin
        out_data_nxt.status = ST_FULL;
      end else begin
        out_data_nxt.status = ST_ACCEPTED;
      end
    end else if (cmd.empty_emit) begin
      out_valid_nxt       = 1'b1;
      out_data_nxt        = '0;
      out_data_nxt.status = ST_EMPTY;
      out_data_nxt.last   = 1'b1;
    end else if (cmd.send_step) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.status        = ST_SENT;
      out_data_nxt.out_packet_id = head_id;
      out_data_nxt.units_sent    = sent;
      out_data_nxt.packet_done   = !split;
      out_data_nxt.tick_total    = total_after;
      out_data_nxt.last          = send_last;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAPACITY_RST;
      leak_rate_r <= LEAK_RATE_RST;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_IDX_CAPACITY:  capacity_r  <= cfg_wdata[CAP_W-1:0];
          CFG_IDX_LEAK_RATE: leak_rate_r <= cfg_wdata[RATE_W-1:0];
        endcase
      end
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.item_load) begin
      item_r <= in_data;
    end
    budget_r   <= budget_nxt;
    total_r    <= total_nxt;
    k_r        <= k_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r != tail_r) |-> (count_r != '0 && count_r != CNT_W'(QUEUE_DEPTH)))
    else $error("head and tail disagree with entry count");

  a_send_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.send_step |-> (count_r != '0))
    else $error("send step on an empty queue");

  a_split_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == ST_SENT && !out_data_r.packet_done)
      |-> out_data_r.last)
    else $error("partial send not marked last");

endmodule

FILE: design/leaky_bucket_packet_shaper_top.sv
`timescale 1ns / 1ps

// Leaky bucket packet shaper. An add request queues a packet (id, size) when
// occupancy plus size fits bucket_capacity and a slot is free, else returns
// over-capacity or queue-full status; it is accepted in the idle state, then
// the result is loaded in the add state once the output is free. A tick
// request is accepted in the idle state, then drains from the FIFO head at
// one result per cycle while the output is not stalled, up to leak_rate
// units and 16 results, splitting the head packet when the budget runs out.
// That pace is set by the queue RAM's single registered read port, which
// always reads the next head entry. An empty tick gives one empty status; a
// tick with a zero leak rate on a non-empty queue gives no result. A new
// request is accepted only when the previous one has produced all its
// results into the output register. Write configuration only while idle.
module leaky_bucket_packet_shaper_top #(
  parameter int QUEUE_DEPTH = lbs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lbs_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lbs_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [lbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lbs_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  lbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lbs_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

FILE: sim/leaky_bucket_packet_shaper_top_tb.sv
`timescale 1ns / 1ps

module leaky_bucket_packet_shaper_top_tb;
  import lbs_pkg::*;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] units;
  } queued_pkt_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow copy of the shaper state and settings
  queued_pkt_t       bucket_fifo[$];
  int unsigned       bucket_level;
  logic [CAP_W-1:0]  cap_setting;
  logic [RATE_W-1:0] rate_setting;

  out_item_t expected_out[$];
  int        fail_count;
  bit        idle_on;

  leaky_bucket_packet_shaper_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Work out the results one accepted request causes
  function automatic void predict_bucket_step(input in_item_t req);
    out_item_t   r;
    queued_pkt_t head;
    int unsigned budget;
    int unsigned total;
    int unsigned sent;
    int          k;
    r = '0;
    if (req.command == CMD_ADD) begin
      r.out_packet_id = req.packet_id;
      r.last = 1'b1;
      if (bucket_level + int'(req.packet_size) > int'(cap_setting)) begin
        r.status = ST_OVER_CAP;
      end else if (bucket_fifo.size() >= QUEUE_DEPTH_DEF) begin
        r.status = ST_FULL;
      end else begin
        head.id = req.packet_id;
        head.units = req.packet_size;
        bucket_fifo.insert(bucket_fifo.size(), head);
        bucket_level += 32'(req.packet_size);
        r.status = ST_ACCEPTED;
      end
      expected_out.insert(expected_out.size(), r);
    end else if (bucket_fifo.size() == 0) begin
      r.status = ST_EMPTY;
      r.last = 1'b1;
      expected_out.insert(expected_out.size(), r);
    end else begin
      budget = 32'(rate_setting);
      total = 0;
      k = 0;
      while (bucket_fifo.size() != 0 && budget != 0 && k < MAX_RESULTS) begin
        head = bucket_fifo.pop_front();
        r.status = ST_SENT;
        r.out_packet_id = head.id;
        if (head.units > budget) begin
          sent = budget;
          head.units = head.units - SIZE_W'(budget);
          bucket_fifo.push_front(head);
          r.packet_done = 1'b0;
        end else begin
          sent = head.units;
          r.packet_done = 1'b1;
        end
        budget -= sent;
        total += sent;
        bucket_level = (bucket_level >= sent) ? bucket_level - sent : 0;
        k++;
        r.units_sent = SIZE_W'(sent);
        r.tick_total = RATE_W'(total);
        r.last = (bucket_fifo.size() == 0 || budget == 0 || k == MAX_RESULTS);
        expected_out.insert(expected_out.size(), r);
      end
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Check results, predict requests and track register writes at each edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_out.size() == 0) begin
          $error("unexpected result: status %0d, id %0d", out_data.status,
                 out_data.out_packet_id);
          fail_count++;
        end else begin
          want = expected_out.pop_front();
          check_field("status", 32'(want.status), 32'(out_data.status));
          check_field("out_packet_id", 32'(want.out_packet_id),
                      32'(out_data.out_packet_id));
          check_field("units_sent", 32'(want.units_sent), 32'(out_data.units_sent));
          check_field("packet_done", 32'(want.packet_done), 32'(out_data.packet_done));
          check_field("tick_total", 32'(want.tick_total), 32'(out_data.tick_total));
          check_field("last", 32'(want.last), 32'(out_data.last));
        end
      end
      if (in_valid && !in_stall) predict_bucket_step(in_data);
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_CAPACITY) cap_setting = cfg_wdata;
        else if (cfg_index == CFG_IDX_LEAK_RATE) rate_setting = cfg_wdata[RATE_W-1:0];
      end
    end
  end

  // Stall the result side in random bursts
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!idle_on || $urandom_range(0, 3) != 0) begin
        out_stall = 1'b0;
      end else begin
        burst = $urandom_range(1, 5);
        out_stall = 1'b1;
        repeat (burst - 1) @(negedge clk);
      end
    end
  end

  // Present one request and hold it until accepted
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                              input logic [SIZE_W-1:0] units);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data = '{command: cmd, packet_id: id, packet_size: units};
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid, drain all results, then let the block settle
  task automatic wait_idle(input int settle);
    in_valid = 1'b0;
    while (expected_out.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_index = idx;
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_bucket(input logic [CAP_W-1:0] cap, input logic [RATE_W-1:0] rate);
    wait_idle(8);
    write_register(CFG_IDX_CAPACITY, cap);
    write_register(CFG_IDX_LEAK_RATE, CFG_DATA_W'(rate));
  endtask

  // Tick at full rate until the queue is empty
  task automatic flush_bucket();
    set_bucket(cap_setting, 16'hFFFF);
    while (bucket_fifo.size() != 0) begin
      send_request(CMD_TICK, ID_W'($urandom), SIZE_W'($urandom));
    end
  endtask

  function automatic logic [SIZE_W-1:0] pick_size(input int max_size);
    case ($urandom_range(0, 9))
      0:       pick_size = '0;
      1:       pick_size = SIZE_W'($urandom_range(0, 16'hFFFF));
      default: pick_size = SIZE_W'($urandom_range(1, max_size));
    endcase
  endfunction

  // Mostly add bursts followed by ticks, with some fully random requests
  task automatic run_traffic(input int n_items, input int max_size);
    int issued;
    int adds;
    int ticks;
    issued = 0;
    while (issued < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(CMD_W'($urandom_range(0, 1)), ID_W'($urandom), SIZE_W'($urandom));
        issued++;
      end else begin
        adds = $urandom_range(1, 18);
        ticks = $urandom_range(1, 4);
        repeat (adds) send_request(CMD_ADD, ID_W'($urandom), pick_size(max_size));
        repeat (ticks) send_request(CMD_TICK, ID_W'($urandom), SIZE_W'($urandom));
        issued += adds + ticks;
      end
    end
  endtask

  // Empty tick, zero-size packet, over-capacity reject and a split head
  task automatic test_empty_and_split();
    send_request(CMD_TICK, 16'h0000, 16'h0000);
    send_request(CMD_ADD, 16'h0000, 16'h0000);
    send_request(CMD_ADD, 16'h0001, 16'd1024);
    send_request(CMD_ADD, 16'hFFFF, 16'd1);
    send_request(CMD_TICK, 16'hFFFF, 16'hFFFF);
  endtask

  // Capacity lowered under the current level keeps queued packets
  task automatic test_capacity_below_occupancy();
    set_bucket(20'd0, 16'hFFFF);
    send_request(CMD_ADD, 16'h1234, 16'h0000);
    send_request(CMD_TICK, 16'h0000, 16'h0000);
    send_request(CMD_ADD, 16'h00FF, 16'h0000);
  endtask

  // A tick with no leak rate on a non-empty queue gives nothing
  task automatic test_zero_leak_rate();
    set_bucket(20'd0, 16'd0);
    send_request(CMD_TICK, 16'h0000, 16'h0000);
  endtask

  // Fill every slot, then hit queue full and both rejections at once
  task automatic test_queue_full();
    set_bucket(20'hFFFFF, 16'hFFFF);
    for (int i = 1; i < QUEUE_DEPTH_DEF; i++) begin
      send_request(CMD_ADD, 16'(i * 16'h1111), 16'hFFFF);
    end
    send_request(CMD_ADD, 16'h5A5A, 16'h0000);
    set_bucket(20'd983025, 16'hFFFF);
    send_request(CMD_ADD, 16'hA5A5, 16'd1);
    flush_bucket();
  endtask

  task automatic test_default_traffic();
    set_bucket(20'd1024, 16'd64);
    run_traffic(40, 200);
  endtask

  task automatic test_slow_leak();
    set_bucket(20'd500, 16'd1);
    run_traffic(30, 40);
  endtask

  // Large budget and mostly small packets, so a tick often drains up to the result limit or the whole queue
  task automatic test_burst_drain();
    set_bucket(20'hFFFFF, 16'hFFFF);
    run_traffic(40, 100);
  endtask

  task automatic test_random_settings();
    set_bucket(CAP_W'($urandom_range(0, 20'hFFFFF)), RATE_W'($urandom_range(1, 16'hFFFF)));
    run_traffic(20, 5000);
    repeat (2) begin
      set_bucket(CAP_W'($urandom_range(50, 3000)), RATE_W'($urandom_range(1, 200)));
      run_traffic(20, 300);
    end
  endtask

  // No idling on either side
  task automatic test_back_to_back();
    set_bucket(20'd4096, 16'd300);
    idle_on = 1'b0;
    run_traffic(40, 400);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    fail_count = 0;
    idle_on = 1'b1;
    bucket_level = 0;
    cap_setting = CAPACITY_RST;
    rate_setting = LEAK_RATE_RST;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_and_split();
    test_capacity_below_occupancy();
    test_zero_leak_rate();
    test_queue_full();
    test_default_traffic();
    test_slow_leak();
    test_burst_drain();
    test_random_settings();
    test_back_to_back();

    wait_idle(30);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Bound the run in case the block hangs
  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule
